@@ rtl/core/npsp_pkg.sv @@
// shared types and constants for the netpbm stream parser
package npsp_pkg;

   localparam int CFG_W = 10;
   localparam int PIX_W = 2 * CFG_W;

   localparam logic [CFG_W-1:0] DIM_RESET = 10'd200;

   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_ONE     = 8'h31;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] GRAY_FULL  = 8'd255;
   localparam int         MAXVAL_REQ = 255;

   localparam logic [3:0] TYPE_PBM = 4'd1;
   localparam logic [3:0] TYPE_PGM = 4'd5;
   localparam logic [3:0] TYPE_PPM = 4'd6;

   localparam logic [1:0] LAST_CHANNEL = 2'd2;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_TYPE,
      PH_NEWLINE,
      PH_WIDTH,
      PH_HEIGHT,
      PH_MAXVAL,
      PH_P1_SEP,
      PH_P1_BIT,
      PH_GRAY,
      PH_RGB
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK,
      ST_UNEXPECTED_END,
      ST_BAD_MAGIC,
      ST_INVALID_TYPE,
      ST_UNEXPECTED_CHAR,
      ST_INVALID_SIZE,
      ST_SIZE_UNWANTED,
      ST_NOT_IMPLEMENTED,
      ST_INVALID_BITS,
      ST_BAD_MAXVAL
   } status_type;

   typedef struct packed {
      logic [3:0] format_digit;
      status_type status;
      logic       done_res;
      logic       pixel_valid;
      logic [7:0] pixel_value;
   } result_type;

endpackage

@@ rtl/core/npsp_parser.sv @@
// header and payload parser, one byte per transfer
module npsp_parser #(
   parameter int MAX_DIGITS = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [7:0]                 data_byte,
   input  logic                       last_byte,
   input  logic [npsp_pkg::CFG_W-1:0] expected_width,
   input  logic [npsp_pkg::CFG_W-1:0] expected_height,
   input  logic [npsp_pkg::PIX_W-1:0] total_pixels,
   output logic                       result_valid,
   output npsp_pkg::result_type       result
);

   localparam int NUM_W = $clog2(10 ** MAX_DIGITS);
   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int CMP_W = (NUM_W > npsp_pkg::CFG_W) ? NUM_W : npsp_pkg::CFG_W;
   localparam int PIX_W = npsp_pkg::PIX_W;

   npsp_pkg::phase_type phase_ff, phase_in;
   logic [3:0]       type_ff, type_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] wseen_ff, wseen_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [1:0]       chan_ff, chan_in;
   logic             fin_ff, fin_in;

   logic             is_digit;
   logic             is_space;
   logic             cnt_full;
   logic [NUM_W-1:0] num_next;
   logic [PIX_W-1:0] pix_plus;
   logic             pix_complete;
   logic             total_zero;
   logic             size_match;
   logic             size_match_in;
   logic             maxval_ok;
   logic             maxval_ok_in;
   logic             pix_hit;
   logic [7:0]       pix_val;
   logic             done;
   npsp_pkg::status_type st;
   logic [3:0]       type_out;

   assign is_digit = (data_byte >= npsp_pkg::CH_ZERO) && (data_byte <= npsp_pkg::CH_NINE);
   assign is_space = data_byte inside {npsp_pkg::CH_SPACE, npsp_pkg::CH_LF,
                                       npsp_pkg::CH_TAB, npsp_pkg::CH_CR};
   assign cnt_full = (cnt_ff >= CNT_W'(MAX_DIGITS));
   assign num_next = NUM_W'(((NUM_W+4)'(num_ff) << 3) + ((NUM_W+4)'(num_ff) << 1)
                            + (NUM_W+4)'(data_byte[3:0]));
   assign pix_plus     = pix_ff + PIX_W'(1);
   assign pix_complete = (pix_plus >= total_pixels);
   assign total_zero   = (total_pixels == '0);

   assign size_match    = (CMP_W'(wseen_ff) == CMP_W'(expected_width))
                       && (CMP_W'(num_ff) == CMP_W'(expected_height));
   assign size_match_in = (CMP_W'(wseen_in) == CMP_W'(expected_width))
                       && (CMP_W'(num_in) == CMP_W'(expected_height));
   assign maxval_ok     = (CMP_W'(num_ff) == CMP_W'(npsp_pkg::MAXVAL_REQ));
   assign maxval_ok_in  = (CMP_W'(num_in) == CMP_W'(npsp_pkg::MAXVAL_REQ));

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      num_in   = num_ff;
      cnt_in   = cnt_ff;
      wseen_in = wseen_ff;
      pix_in   = pix_ff;
      chan_in  = chan_ff;
      fin_in   = fin_ff;
      pix_hit  = 1'b0;
      pix_val  = '0;
      done     = 1'b0;
      st       = npsp_pkg::ST_OK;

      if (!fin_ff) begin
         case (phase_ff)
            npsp_pkg::PH_MAGIC: begin
               if (data_byte != npsp_pkg::CH_P) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_BAD_MAGIC;
               end else begin
                  phase_in = npsp_pkg::PH_TYPE;
               end
            end
            npsp_pkg::PH_TYPE: begin
               if (!is_digit) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_INVALID_TYPE;
               end else begin
                  type_in  = data_byte[3:0];
                  phase_in = npsp_pkg::PH_NEWLINE;
               end
            end
            npsp_pkg::PH_NEWLINE: begin
               if (data_byte != npsp_pkg::CH_LF) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_UNEXPECTED_CHAR;
               end else begin
                  num_in   = '0;
                  cnt_in   = '0;
                  phase_in = npsp_pkg::PH_WIDTH;
               end
            end
            npsp_pkg::PH_WIDTH, npsp_pkg::PH_HEIGHT, npsp_pkg::PH_MAXVAL: begin
               if (is_digit) begin
                  if (cnt_full) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_INVALID_SIZE;
                  end else begin
                     cnt_in = cnt_ff + CNT_W'(1);
                     num_in = num_next;
                  end
               end else if (cnt_ff == '0) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_UNEXPECTED_END;
               end else if (phase_ff == npsp_pkg::PH_WIDTH) begin
                  if (!is_space) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_INVALID_SIZE;
                  end else begin
                     wseen_in = num_ff;
                     num_in   = '0;
                     cnt_in   = '0;
                     phase_in = npsp_pkg::PH_HEIGHT;
                  end
               end else if (phase_ff == npsp_pkg::PH_HEIGHT) begin
                  if (!size_match) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_SIZE_UNWANTED;
                  end else if (!is_space) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_INVALID_SIZE;
                  end else if (type_ff inside {4'd0, 4'd8, 4'd9}) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_INVALID_TYPE;
                  end else if (type_ff == npsp_pkg::TYPE_PBM) begin
                     if (total_zero) begin
                        done = 1'b1;
                     end else begin
                        phase_in = npsp_pkg::PH_P1_SEP;
                     end
                  end else if (type_ff == npsp_pkg::TYPE_PGM
                               || type_ff == npsp_pkg::TYPE_PPM) begin
                     num_in   = '0;
                     cnt_in   = '0;
                     phase_in = npsp_pkg::PH_MAXVAL;
                  end else begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_NOT_IMPLEMENTED;
                  end
               end else begin
                  if (!maxval_ok) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_BAD_MAXVAL;
                  end else if (!is_space) begin
                     done = 1'b1;
                     st   = npsp_pkg::ST_UNEXPECTED_CHAR;
                  end else if (total_zero) begin
                     done = 1'b1;
                  end else begin
                     chan_in  = '0;
                     phase_in = (type_ff == npsp_pkg::TYPE_PGM) ? npsp_pkg::PH_GRAY
                                                                : npsp_pkg::PH_RGB;
                  end
               end
            end
            npsp_pkg::PH_P1_SEP: begin
               if (!is_space) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_UNEXPECTED_CHAR;
               end else begin
                  phase_in = npsp_pkg::PH_P1_BIT;
               end
            end
            npsp_pkg::PH_P1_BIT: begin
               if (data_byte == npsp_pkg::CH_ONE || data_byte == npsp_pkg::CH_ZERO) begin
                  pix_hit = 1'b1;
                  pix_val = (data_byte == npsp_pkg::CH_ONE) ? npsp_pkg::GRAY_FULL : 8'd0;
                  pix_in  = pix_plus;
                  if (pix_complete) begin
                     done = 1'b1;
                  end else begin
                     phase_in = npsp_pkg::PH_P1_SEP;
                  end
               end else begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_INVALID_BITS;
               end
            end
            npsp_pkg::PH_GRAY: begin
               pix_hit = 1'b1;
               pix_val = data_byte;
               pix_in  = pix_plus;
               done    = pix_complete;
            end
            npsp_pkg::PH_RGB: begin
               if (chan_ff == '0) begin
                  pix_hit = 1'b1;
                  pix_val = data_byte;
               end
               if (chan_ff >= npsp_pkg::LAST_CHANNEL) begin
                  chan_in = '0;
                  pix_in  = pix_plus;
                  done    = pix_complete;
               end else begin
                  chan_in = chan_ff + 2'd1;
               end
            end
            default: begin
               done = 1'b1;
               st   = npsp_pkg::ST_UNEXPECTED_END;
            end
         endcase

         if (last_byte && !done) begin
            done = 1'b1;
            st   = npsp_pkg::ST_UNEXPECTED_END;
            if (phase_in == npsp_pkg::PH_HEIGHT && cnt_in != '0 && !size_match_in) begin
               st = npsp_pkg::ST_SIZE_UNWANTED;
            end else if (phase_in == npsp_pkg::PH_MAXVAL && cnt_in != '0
                         && !maxval_ok_in) begin
               st = npsp_pkg::ST_BAD_MAXVAL;
            end
         end
         if (done) begin
            fin_in = 1'b1;
         end
      end

      type_out = type_in;

      if (last_byte) begin
         phase_in = npsp_pkg::PH_MAGIC;
         type_in  = '0;
         num_in   = '0;
         cnt_in   = '0;
         wseen_in = '0;
         pix_in   = '0;
         chan_in  = '0;
         fin_in   = 1'b0;
      end
   end

   assign result_valid        = accept && (pix_hit || done);
   assign result.pixel_value  = pix_val;
   assign result.pixel_valid  = pix_hit;
   assign result.done_res     = done;
   assign result.status       = done ? st : npsp_pkg::ST_OK;
   assign result.format_digit = type_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= npsp_pkg::PH_MAGIC;
         type_ff  <= '0;
         num_ff   <= '0;
         cnt_ff   <= '0;
         wseen_ff <= '0;
         pix_ff   <= '0;
         chan_ff  <= '0;
         fin_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         num_ff   <= num_in;
         cnt_ff   <= cnt_in;
         wseen_ff <= wseen_in;
         pix_ff   <= pix_in;
         chan_ff  <= chan_in;
         fin_ff   <= fin_in;
      end
   end

endmodule

@@ rtl/core/npsp_skid.sv @@
// two-entry result buffer with a registered ready
module npsp_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  npsp_pkg::result_type in_data,
   output logic                 in_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output npsp_pkg::result_type out_data
);

   logic                 out_valid_ff, out_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   npsp_pkg::result_type out_data_ff;
   npsp_pkg::result_type skid_data_ff;
   logic                 out_fire;

   assign out_fire  = out_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_fire) begin
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_valid_ff && !out_ready) begin
            skid_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b1;
         end
      end else if (out_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_fire) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (in_valid) begin
         if (out_valid_ff && !out_ready) begin
            skid_data_ff <= in_data;
         end else begin
            out_data_ff <= in_data;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output stage empty");

endmodule

@@ rtl/core/netpbm_stream_parser_top.sv @@
// top level of the netpbm stream parser
// Parses a P1, P5 or P6 file one byte per clock and emits one gray pixel per
// decoded pixel, and sets done and a status code on the final transfer of a
// file. Each byte is decoded in the cycle it is taken and its result is
// registered in a two-entry output buffer, which keeps req_tready high until
// both of its entries are full; this gives a sustained rate of one byte per
// cycle while rsp_tready stays high. The expected width and height must be
// written over the csr port while no file is in flight; the block itself does
// not enforce this. Their product is registered from the stored width and height.
module netpbm_stream_parser_top #(
   parameter int MAX_DIGITS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // pixel_value[7:0], status[11:8], format_digit[15:12]
   output logic        rsp_tuser,   // pixel_valid
   output logic        rsp_tlast,   // done_res
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   localparam int CFG_W = npsp_pkg::CFG_W;
   localparam int PIX_W = npsp_pkg::PIX_W;

   logic [CFG_W-1:0]     exp_width_ff;
   logic [CFG_W-1:0]     exp_height_ff;
   logic [PIX_W-1:0]     total_ff;
   logic                 accept;
   logic                 res_valid;
   npsp_pkg::result_type res;
   npsp_pkg::result_type out_res;

   assign csr_ready = 1'b1;
   assign accept    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_width_ff  <= npsp_pkg::DIM_RESET;
         exp_height_ff <= npsp_pkg::DIM_RESET;
         total_ff      <= PIX_W'(npsp_pkg::DIM_RESET) * PIX_W'(npsp_pkg::DIM_RESET);
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == npsp_pkg::CSR_WIDTH) begin
               exp_width_ff <= csr_data;
            end else begin
               exp_height_ff <= csr_data;
            end
         end
         total_ff <= PIX_W'(exp_width_ff) * PIX_W'(exp_height_ff);
      end
   end

   npsp_parser #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_parser (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_tdata),
      .last_byte       (req_tlast),
      .expected_width  (exp_width_ff),
      .expected_height (exp_height_ff),
      .total_pixels    (total_ff),
      .result_valid    (res_valid),
      .result          (res)
   );

   npsp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_res)
   );

   assign rsp_tdata = {out_res.format_digit, 4'(out_res.status), out_res.pixel_value};
   assign rsp_tuser = out_res.pixel_valid;
   assign rsp_tlast = out_res.done_res;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser || rsp_tlast))
      else $error("result transfer with neither pixel nor done");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[11:8] == 4'd0))
      else $error("status set on a transfer that is not done");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("pixel value set without pixel valid");

   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (total_ff != $past(total_ff) || 1'b1)
         ##1 (total_ff == PIX_W'(exp_width_ff) * PIX_W'(exp_height_ff)
              || $past(csr_valid)))
      else $error("pixel total not updated after a csr write");

endmodule

@@ sim/netpbm_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the netpbm stream parser: predicts every result and checks the rsp channel
module netpbm_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data,
   output int          fail_count,
   output int          due_count,
   output int          byte_count,
   output int          rsp_count,
   output int          file_count,
   output logic [9:0]  status_seen
);

   localparam int DIGITS_MAX = 3;

   localparam logic [3:0] KIND_ZERO  = 4'd0;
   localparam logic [3:0] KIND_EIGHT = 4'd8;
   localparam logic [3:0] KIND_NINE  = 4'd9;

   npsp_pkg::phase_type   ph;
   logic [3:0]            kind;
   logic [9:0]            num;
   logic [2:0]            ndig;
   logic [9:0]            wseen;
   logic [19:0]           npix;
   logic [1:0]            chan;
   logic                  fin;
   logic [9:0]            want_w;
   logic [9:0]            want_h;
   npsp_pkg::result_type  due_results[$];

   function automatic logic is_digit(logic [7:0] b);
      return b >= npsp_pkg::CH_ZERO && b <= npsp_pkg::CH_NINE;
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return b == npsp_pkg::CH_SPACE || b == npsp_pkg::CH_LF
          || b == npsp_pkg::CH_TAB || b == npsp_pkg::CH_CR;
   endfunction

   function automatic logic size_match();
      return wseen == want_w && num == want_h;
   endfunction

   // returns 1 when the digit is one too many
   function automatic logic grow_number(logic [7:0] b);
      if (ndig >= DIGITS_MAX) return 1'b1;
      ndig = ndig + 3'd1;
      num  = 10'(num * 10 + (b - npsp_pkg::CH_ZERO));
      return 1'b0;
   endfunction

   task automatic restart_file();
      ph    = npsp_pkg::PH_MAGIC;
      kind  = '0;
      num   = '0;
      ndig  = '0;
      wseen = '0;
      npix  = '0;
      chan  = '0;
      fin   = 1'b0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic l, output logic emit,
                             output npsp_pkg::result_type r);
      logic                 pix;
      logic                 done;
      logic [7:0]           pv;
      npsp_pkg::status_type st;
      int                   total;
      pix   = 1'b0;
      done  = 1'b0;
      pv    = '0;
      st    = npsp_pkg::ST_OK;
      total = int'(want_w) * int'(want_h);
      if (!fin) begin
         case (ph)
            npsp_pkg::PH_MAGIC: begin
               if (b != npsp_pkg::CH_P) begin done = 1'b1; st = npsp_pkg::ST_BAD_MAGIC; end
               else ph = npsp_pkg::PH_TYPE;
            end
            npsp_pkg::PH_TYPE: begin
               if (!is_digit(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_TYPE; end
               else begin kind = 4'(b - npsp_pkg::CH_ZERO); ph = npsp_pkg::PH_NEWLINE; end
            end
            npsp_pkg::PH_NEWLINE: begin
               if (b != npsp_pkg::CH_LF) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_UNEXPECTED_CHAR;
               end else begin
                  num  = '0;
                  ndig = '0;
                  ph   = npsp_pkg::PH_WIDTH;
               end
            end
            npsp_pkg::PH_WIDTH: begin
               if (is_digit(b)) begin
                  if (grow_number(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_SIZE; end
               end else if (ndig == 0) begin done = 1'b1; st = npsp_pkg::ST_UNEXPECTED_END; end
               else if (!is_space(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_SIZE; end
               else begin wseen = num; num = '0; ndig = '0; ph = npsp_pkg::PH_HEIGHT; end
            end
            npsp_pkg::PH_HEIGHT: begin
               if (is_digit(b)) begin
                  if (grow_number(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_SIZE; end
               end else if (ndig == 0) begin done = 1'b1; st = npsp_pkg::ST_UNEXPECTED_END; end
               else if (!size_match()) begin done = 1'b1; st = npsp_pkg::ST_SIZE_UNWANTED; end
               else if (!is_space(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_SIZE; end
               else if (kind == KIND_ZERO || kind == KIND_EIGHT || kind == KIND_NINE) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_INVALID_TYPE;
               end else if (kind == npsp_pkg::TYPE_PBM) begin
                  if (total == 0) done = 1'b1;
                  else ph = npsp_pkg::PH_P1_SEP;
               end else if (kind == npsp_pkg::TYPE_PGM || kind == npsp_pkg::TYPE_PPM) begin
                  num  = '0;
                  ndig = '0;
                  ph   = npsp_pkg::PH_MAXVAL;
               end else begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_NOT_IMPLEMENTED;
               end
            end
            npsp_pkg::PH_MAXVAL: begin
               if (is_digit(b)) begin
                  if (grow_number(b)) begin done = 1'b1; st = npsp_pkg::ST_INVALID_SIZE; end
               end else if (ndig == 0) begin done = 1'b1; st = npsp_pkg::ST_UNEXPECTED_END; end
               else if (num != npsp_pkg::MAXVAL_REQ) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_BAD_MAXVAL;
               end else if (!is_space(b)) begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_UNEXPECTED_CHAR;
               end else if (total == 0) done = 1'b1;
               else begin
                  chan = '0;
                  ph   = (kind == npsp_pkg::TYPE_PGM) ? npsp_pkg::PH_GRAY : npsp_pkg::PH_RGB;
               end
            end
            npsp_pkg::PH_P1_SEP: begin
               if (!is_space(b)) begin done = 1'b1; st = npsp_pkg::ST_UNEXPECTED_CHAR; end
               else ph = npsp_pkg::PH_P1_BIT;
            end
            npsp_pkg::PH_P1_BIT: begin
               if (b == npsp_pkg::CH_ONE || b == npsp_pkg::CH_ZERO) begin
                  pix  = 1'b1;
                  pv   = (b == npsp_pkg::CH_ONE) ? npsp_pkg::GRAY_FULL : 8'd0;
                  npix = npix + 20'd1;
                  if (int'(npix) >= total) done = 1'b1;
                  else ph = npsp_pkg::PH_P1_SEP;
               end else begin
                  done = 1'b1;
                  st   = npsp_pkg::ST_INVALID_BITS;
               end
            end
            npsp_pkg::PH_GRAY: begin
               pix  = 1'b1;
               pv   = b;
               npix = npix + 20'd1;
               if (int'(npix) >= total) done = 1'b1;
            end
            npsp_pkg::PH_RGB: begin
               if (chan == 0) begin pix = 1'b1; pv = b; end
               if (chan >= npsp_pkg::LAST_CHANNEL) begin
                  chan = '0;
                  npix = npix + 20'd1;
                  if (int'(npix) >= total) done = 1'b1;
               end else begin
                  chan = chan + 2'd1;
               end
            end
            default: begin
               done = 1'b1;
               st   = npsp_pkg::ST_UNEXPECTED_END;
            end
         endcase
         if (l && !done) begin
            done = 1'b1;
            st   = npsp_pkg::ST_UNEXPECTED_END;
            if (ph == npsp_pkg::PH_HEIGHT && ndig != 0 && !size_match())
               st = npsp_pkg::ST_SIZE_UNWANTED;
            else if (ph == npsp_pkg::PH_MAXVAL && ndig != 0 && num != npsp_pkg::MAXVAL_REQ)
               st = npsp_pkg::ST_BAD_MAXVAL;
         end
         if (done) fin = 1'b1;
      end
      emit          = pix || done;
      r.pixel_value = pix ? pv : 8'd0;
      r.pixel_valid = pix;
      r.done_res    = done;
      r.status      = done ? st : npsp_pkg::ST_OK;
      r.format_digit = kind;
      if (l) restart_file();
   endtask

   task automatic report_mismatch(string what, int got, int want);
      fail_count++;
      if (fail_count <= 40)
         $display("mismatch at result %0d: %s got %0d want %0d", rsp_count, what, got, want);
   endtask

   always @(posedge clock) begin : watch
      npsp_pkg::result_type want;
      npsp_pkg::result_type fresh;
      logic                 emit;
      if (reset) begin
         restart_file();
         want_w = npsp_pkg::DIM_RESET;
         want_h = npsp_pkg::DIM_RESET;
         due_results.delete();
         fail_count  = 0;
         byte_count  = 0;
         rsp_count   = 0;
         file_count  = 0;
         status_seen = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == npsp_pkg::CSR_WIDTH) want_w = csr_data;
            else want_h = csr_data;
         end
         if (req_tvalid && req_tready) begin
            byte_count++;
            if (req_tlast) file_count++;
            parse_byte(req_tdata, req_tlast, emit, fresh);
            if (emit) begin
               due_results.push_back(fresh);
               if (fresh.done_res) status_seen[fresh.status] = 1'b1;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (due_results.size() == 0) begin
               report_mismatch("result with nothing due, tdata", int'(rsp_tdata), 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_tdata[7:0] != want.pixel_value)
                  report_mismatch("pixel_value", int'(rsp_tdata[7:0]),
                                  int'(want.pixel_value));
               if (rsp_tuser != want.pixel_valid)
                  report_mismatch("pixel_valid", int'(rsp_tuser), int'(want.pixel_valid));
               if (rsp_tlast != want.done_res)
                  report_mismatch("done_res", int'(rsp_tlast), int'(want.done_res));
               if (rsp_tdata[11:8] != want.status)
                  report_mismatch("status", int'(rsp_tdata[11:8]), int'(want.status));
               if (rsp_tdata[15:12] != want.format_digit)
                  report_mismatch("format_digit", int'(rsp_tdata[15:12]),
                                  int'(want.format_digit));
            end
         end
      end
      due_count = due_results.size();
   end

endmodule

@@ sim/tb_netpbm_stream_parser_top.sv @@
`timescale 1ns / 100ps
// testbench top for the netpbm stream parser: stimulus, clock, reset and verdict
module tb_netpbm_stream_parser_top;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [9:0]  csr_data;

   int          fail_count;
   int          due_count;
   int          byte_count;
   int          rsp_count;
   int          file_count;
   logic [9:0]  status_seen;

   logic [7:0]  file_bytes[$];
   logic        no_idle;
   int          sent_random;
   int          cur_w;
   int          cur_h;
   int          phase_no;

   netpbm_stream_parser_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   netpbm_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .due_count   (due_count),
      .byte_count  (byte_count),
      .rsp_count   (rsp_count),
      .file_count  (file_count),
      .status_seen (status_seen)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 600000);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(0, 3))
         0: return npsp_pkg::CH_SPACE;
         1: return npsp_pkg::CH_LF;
         2: return npsp_pkg::CH_TAB;
         default: return npsp_pkg::CH_CR;
      endcase
   endfunction

   task automatic send_byte(logic [7:0] b, logic l);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_text(string s, logic l);
      for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), l && i == s.len() - 1);
   endtask

   task automatic send_file();
      no_idle = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < file_bytes.size(); i++)
         send_byte(file_bytes[i], i == file_bytes.size() - 1);
      sent_random += file_bytes.size();
   endtask

   // drop valid and let the block drain before touching the registers
   task automatic settle();
      req_tvalid <= 1'b0;
      wait (due_count == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_size(int w, int h);
      cur_w = w;
      cur_h = h;
      csr_valid <= 1'b1;
      csr_index <= npsp_pkg::CSR_WIDTH;
      csr_data  <= 10'(w);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= npsp_pkg::CSR_HEIGHT;
      csr_data  <= 10'(h);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      repeat (2) @(negedge clock);
   endtask

   task automatic put_blank();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) file_bytes.push_back(8'($urandom));
      else file_bytes.push_back(blank_byte());
      if (pick >= 98) file_bytes.push_back(blank_byte());
   endtask

   task automatic put_number(int v);
      string s;
      int    pick;
      pick = $urandom_range(0, 99);
      if (pick < 2) return;
      if (pick < 4) v = $urandom_range(1000, 9999);
      else if (pick < 8) v = $urandom_range(0, 999);
      else if (pick < 9) v = v + 1;
      s = $sformatf("%0d", v);
      if (pick == 9) s = {"0", s};
      for (int i = 0; i < s.len(); i++) file_bytes.push_back(8'(s[i]));
   endtask

   task automatic make_file();
      int pick;
      int kind;
      int total;
      int npx;
      int keep;
      file_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         repeat ($urandom_range(1, 10)) file_bytes.push_back(8'($urandom));
         return;
      end
      file_bytes.push_back(pick < 8 ? 8'($urandom) : npsp_pkg::CH_P);
      pick = $urandom_range(0, 99);
      if (pick < 30) kind = npsp_pkg::TYPE_PBM;
      else if (pick < 60) kind = npsp_pkg::TYPE_PGM;
      else if (pick < 88) kind = npsp_pkg::TYPE_PPM;
      else if (pick < 96) kind = $urandom_range(0, 9);
      else kind = -1;
      if (kind < 0) file_bytes.push_back(8'($urandom));
      else file_bytes.push_back(npsp_pkg::CH_ZERO + 8'(kind));
      file_bytes.push_back($urandom_range(0, 99) < 3 ? 8'($urandom) : npsp_pkg::CH_LF);
      put_number(cur_w);
      put_blank();
      put_number(cur_h);
      put_blank();
      if (kind == npsp_pkg::TYPE_PGM || kind == npsp_pkg::TYPE_PPM) begin
         put_number(npsp_pkg::MAXVAL_REQ);
         put_blank();
      end
      total = cur_w * cur_h;
      npx   = (total > 40) ? $urandom_range(0, 40) : total;
      for (int i = 0; i < npx; i++) begin
         if (kind == npsp_pkg::TYPE_PBM) begin
            file_bytes.push_back($urandom_range(0, 99) < 2 ? 8'($urandom) : blank_byte());
            if ($urandom_range(0, 99) < 2) file_bytes.push_back(8'($urandom));
            else file_bytes.push_back($urandom_range(0, 1) ? npsp_pkg::CH_ONE
                                                           : npsp_pkg::CH_ZERO);
         end else if (kind == npsp_pkg::TYPE_PGM) begin
            file_bytes.push_back(8'($urandom));
         end else begin
            repeat (3) file_bytes.push_back(8'($urandom));
         end
      end
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
      // truncated file
      if ($urandom_range(0, 99) < 6 && file_bytes.size() > 1) begin
         keep = $urandom_range(1, file_bytes.size() - 1);
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin : drain
         int gap;
         gap = no_idle ? 0 : $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int nfiles;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = npsp_pkg::CSR_WIDTH;
      csr_data    = '0;
      no_idle     = 1'b0;
      sent_random = 0;
      phase_no    = 0;
      cur_w       = npsp_pkg::DIM_RESET;
      cur_h       = npsp_pkg::DIM_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // header faults and a random file at the reset size, then small P1 and P5 files at 2 by 1
      send_text("Q", 1'b1);
      send_text("Px", 1'b1);
      make_file();
      send_file();
      settle();
      set_size(2, 1);
      send_text("P1\n2 1\n 0\t1", 1'b1);
      send_text("P5\n2 1\n255\r", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);

      while (sent_random < 1400) begin
         settle();
         case (phase_no)
            0: set_size(0, 0);
            1: set_size(1, 1);
            2: set_size(999, 999);
            3: set_size(999, 0);
            4: set_size(0, 999);
            default: begin
               if ($urandom_range(0, 4) == 0)
                  set_size($urandom_range(0, 999), $urandom_range(0, 999));
               else
                  set_size($urandom_range(0, 6), $urandom_range(1, 6));
            end
         endcase
         phase_no++;
         nfiles = $urandom_range(4, 8);
         repeat (nfiles) begin
            make_file();
            send_file();
         end
      end
      settle();
      repeat (12) @(posedge clock);

      $display("%0d bytes in %0d files gave %0d results over %0d size settings",
               byte_count, file_count, rsp_count, phase_no + 1);
      $display("status codes reached, one bit per code from 0 up: %b", status_seen);
      if (fail_count == 0 && due_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
